// File: rtl/vha_pkg.sv
// Shared types, widths and constants of the vector heading angle block.
package vha_pkg;

    // Field widths
    localparam int COMP_W    = 16;
    localparam int HEADING_W = 15;

    // Datapath widths
    localparam int CW        = 35;   // CORDIC x/y, components scaled by 2^16 plus gain
    localparam int ZW        = 40;   // CORDIC angle accumulator, 1e-9 degree units
    localparam int AW        = 41;   // signed angle before wrapping
    localparam int ANG_W     = 39;   // wrapped angle, 0 up to 360e9
    localparam int TABLE_LEN = 24;

    localparam logic [63:0] NDEG_PER_DEG = 64'd1_000_000_000;
    localparam logic [63:0] HALF_NDEG    = 64'd500_000_000;

    localparam logic signed [AW-1:0] RIGHT_NDEG = 41'sd90_000_000_000;
    localparam logic signed [AW-1:0] FULL_NDEG  = 41'sd360_000_000_000;

    // atan(2^-i) in 1e-9 degree
    localparam logic signed [ZW-1:0] ATAN_NDEG [TABLE_LEN] = '{
        40'sd45000000000, 40'sd26565051177, 40'sd14036243468, 40'sd7125016349,
        40'sd3576334375,  40'sd1789910608,  40'sd895173710,   40'sd447614171,
        40'sd223810500,   40'sd111905677,   40'sd55952892,    40'sd27976453,
        40'sd13988227,    40'sd6994114,     40'sd3497057,     40'sd1748528,
        40'sd874264,      40'sd437132,      40'sd218566,      40'sd109283,
        40'sd54642,       40'sd27321,       40'sd13660,       40'sd6830
    };

    // Quadrant tag that travels beside the CORDIC data.
    // qidx: base angle in quarter turns plus one, reference offset already applied.
    typedef struct packed {
        logic       zero;
        logic [2:0] qidx;
        logic       use_t;
        logic       t_neg;
    } tag_t;

    // Base angle of a quarter index: (qidx - 1) * 90 degrees
    function automatic logic signed [AW-1:0] quarter_ndeg(input logic [2:0] qidx);
        logic signed [AW-1:0] base;
        unique case (qidx)
            3'd0:    base = -RIGHT_NDEG;
            3'd2:    base = 41'sd90_000_000_000;
            3'd3:    base = 41'sd180_000_000_000;
            3'd4:    base = 41'sd270_000_000_000;
            3'd5:    base = 41'sd360_000_000_000;
            default: base = '0;
        endcase
        return base;
    endfunction

endpackage

// File: rtl/vha_ifs.sv
// Valid/ready channel interfaces for input vectors and heading results.
interface vha_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [vha_pkg::COMP_W-1:0]   x_component;
    logic signed [vha_pkg::COMP_W-1:0]   y_component;

    modport source (output valid, x_component, y_component, input ready);
    modport sink   (input valid, x_component, y_component, output ready);
    modport mon    (input valid, ready, x_component, y_component);
endinterface

interface vha_out_if;
    logic                                valid;
    logic                                ready;
    logic [vha_pkg::HEADING_W-1:0]       heading;
    logic                                zero_vector;

    modport source (output valid, heading, zero_vector, input ready);
    modport sink   (input valid, heading, zero_vector, output ready);
    modport mon    (input valid, ready, heading, zero_vector);
endinterface

// File: rtl/vha_cordic.sv
// Input classification and vectoring CORDIC pipeline, one rotation per stage.
module vha_cordic #(
    parameter int STAGES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic signed [vha_pkg::COMP_W-1:0]  x_component,
    input  logic signed [vha_pkg::COMP_W-1:0]  y_component,
    input  logic                               north,
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output logic signed [vha_pkg::ZW-1:0]      angle_z,
    output vha_pkg::tag_t                      tag
);

    localparam int RUN = (STAGES < vha_pkg::TABLE_LEN) ? STAGES : vha_pkg::TABLE_LEN;

    logic [RUN:0]   v_reg;
    logic [RUN+1:0] rdy;

    logic signed [vha_pkg::CW-1:0] cx_reg [0:RUN];
    logic signed [vha_pkg::CW-1:0] cy_reg [0:RUN];
    logic signed [vha_pkg::ZW-1:0] z_reg  [0:RUN];
    vha_pkg::tag_t                 tag_reg [0:RUN];

    logic signed [vha_pkg::COMP_W:0] xs, ys, ax, ay;
    logic signed [vha_pkg::CW-1:0]   cx0, cy0;
    vha_pkg::tag_t                   tag0;
    logic [2:0]                      base;

    assign rdy[RUN+1] = dn_ready;
    assign up_ready   = rdy[0];
    assign dn_valid   = v_reg[RUN];
    assign angle_z    = z_reg[RUN];
    assign tag        = tag_reg[RUN];

    // Absolute values and quadrant class
    always_comb
    begin
        xs   = (vha_pkg::COMP_W+1)'(x_component);
        ys   = (vha_pkg::COMP_W+1)'(y_component);
        ax   = xs[vha_pkg::COMP_W] ? -xs : xs;
        ay   = ys[vha_pkg::COMP_W] ? -ys : ys;
        cx0  = vha_pkg::CW'(ax) << 16;
        cy0  = vha_pkg::CW'(ay) << 16;
        tag0 = '0;
        base = 3'd0;
        if (xs == '0 && ys == '0)
        begin
            tag0.zero = 1'b1;
        end
        else if (xs == '0)
        begin
            base = (ys > 0) ? 3'd1 : 3'd3;
        end
        else if (ys == '0)
        begin
            base = (xs > 0) ? 3'd0 : 3'd2;
        end
        else
        begin
            tag0.use_t = 1'b1;
            if (xs > 0 && ys > 0)
            begin
                base = 3'd0;
            end
            else if (ys > 0)
            begin
                base = 3'd2;
                tag0.t_neg = 1'b1;
            end
            else if (xs < 0)
            begin
                base = 3'd2;
            end
            else
            begin
                base = 3'd4;
                tag0.t_neg = 1'b1;
            end
        end
        // Offset by one quarter, less one more when measuring from north
        tag0.qidx = base + 3'd1 - {2'b00, north};
    end

    genvar k;
    generate
        for (k = 0; k <= RUN; k++)
        begin : g_stage
            assign rdy[k] = !v_reg[k] || rdy[k+1];

            if (k == 0)
            begin : g_load
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        v_reg[0] <= 1'b0;
                    else if (rdy[0])
                        v_reg[0] <= up_valid;
                end

                always_ff @(posedge clk)
                begin
                    if (rdy[0] && up_valid)
                    begin
                        cx_reg[0]  <= cx0;
                        cy_reg[0]  <= cy0;
                        z_reg[0]   <= '0;
                        tag_reg[0] <= tag0;
                    end
                end
            end
            else
            begin : g_rot
                logic signed [vha_pkg::CW-1:0] dx, dy, cx_next, cy_next;
                logic signed [vha_pkg::ZW-1:0] z_next;

                // Rotate toward the x axis by atan(2^-(k-1))
                always_comb
                begin
                    dx = cy_reg[k-1] >>> (k-1);
                    dy = cx_reg[k-1] >>> (k-1);
                    if (cy_reg[k-1] >= 0)
                    begin
                        cx_next = cx_reg[k-1] + dx;
                        cy_next = cy_reg[k-1] - dy;
                        z_next  = z_reg[k-1] + vha_pkg::ATAN_NDEG[k-1];
                    end
                    else
                    begin
                        cx_next = cx_reg[k-1] - dx;
                        cy_next = cy_reg[k-1] + dy;
                        z_next  = z_reg[k-1] - vha_pkg::ATAN_NDEG[k-1];
                    end
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        v_reg[k] <= 1'b0;
                    else if (rdy[k])
                        v_reg[k] <= v_reg[k-1];
                end

                always_ff @(posedge clk)
                begin
                    if (rdy[k] && v_reg[k-1])
                    begin
                        cx_reg[k]  <= cx_next;
                        cy_reg[k]  <= cy_next;
                        z_reg[k]   <= z_next;
                        tag_reg[k] <= tag_reg[k-1];
                    end
                end
            end
        end
    endgenerate

endmodule

// File: rtl/vha_angle.sv
// Clamp, quadrant placement and wrap of the CORDIC angle into 0 up to 360 degrees.
module vha_angle (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic signed [vha_pkg::ZW-1:0]  angle_z,
    input  vha_pkg::tag_t                  tag,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output logic [vha_pkg::ANG_W-1:0]      angle,
    output logic                           zero
);

    logic [2:0] v_reg;
    logic [3:0] rdy;

    logic signed [vha_pkg::AW-1:0] t_reg, t_next;
    logic signed [vha_pkg::AW-1:0] a_reg, a_next;
    logic [vha_pkg::ANG_W-1:0]     ang_reg, ang_next;
    vha_pkg::tag_t                 tag0_reg, tag1_reg;
    logic                          zero_reg;
    logic signed [vha_pkg::AW-1:0] zx;

    assign rdy[3]   = dn_ready;
    assign rdy[0]   = !v_reg[0] || rdy[1];
    assign rdy[1]   = !v_reg[1] || rdy[2];
    assign rdy[2]   = !v_reg[2] || rdy[3];
    assign up_ready = rdy[0];
    assign dn_valid = v_reg[2];
    assign angle    = ang_reg;
    assign zero     = zero_reg;

    // Clamp the first-quadrant angle to 0..90 degrees
    always_comb
    begin
        zx = vha_pkg::AW'(angle_z);
        if (zx < 0)
            t_next = '0;
        else if (zx > vha_pkg::RIGHT_NDEG)
            t_next = vha_pkg::RIGHT_NDEG;
        else
            t_next = zx;
    end

    // Place into its quadrant, reference offset included
    always_comb
    begin
        a_next = vha_pkg::quarter_ndeg(tag0_reg.qidx);
        if (tag0_reg.use_t)
            a_next = tag0_reg.t_neg ? a_next - t_reg : a_next + t_reg;
    end

    // Wrap by one full turn either way
    always_comb
    begin
        if (a_reg < 0)
            ang_next = vha_pkg::ANG_W'(a_reg + vha_pkg::FULL_NDEG);
        else if (a_reg >= vha_pkg::FULL_NDEG)
            ang_next = vha_pkg::ANG_W'(a_reg - vha_pkg::FULL_NDEG);
        else
            ang_next = vha_pkg::ANG_W'(a_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= up_valid;
            if (rdy[1])
                v_reg[1] <= v_reg[0];
            if (rdy[2])
                v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && up_valid)
        begin
            t_reg    <= t_next;
            tag0_reg <= tag;
        end
        if (rdy[1] && v_reg[0])
        begin
            a_reg    <= a_next;
            tag1_reg <= tag0_reg;
        end
        if (rdy[2] && v_reg[1])
        begin
            ang_reg  <= ang_next;
            zero_reg <= tag1_reg.zero;
        end
    end

endmodule

// File: rtl/vha_divide.sv
// Rounded conversion to fixed-point degrees by reciprocal multiply and one correction step.
module vha_divide #(
    parameter int FRACTION_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic [vha_pkg::ANG_W-1:0]         angle,
    input  logic                              zero,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic [vha_pkg::HEADING_W-1:0]     heading,
    output logic                              zero_vector
);

    localparam int QW = 9 + FRACTION_BITS;
    localparam int DW = vha_pkg::ANG_W + FRACTION_BITS;
    localparam int SH = DW - 32;
    localparam logic [DW-1:0] DIVISOR = DW'(vha_pkg::NDEG_PER_DEG);
    localparam logic [DW-1:0] BIAS    = DW'(vha_pkg::HALF_NDEG);
    localparam logic [QW-1:0] FULL_Q  = QW'(360) << FRACTION_BITS;
    // floor(2^DW / 1e9); with the top 32 bits of the scaled angle the
    // estimate is exact or one short
    localparam logic [31:0]   RECIP   = 32'((64'd1 << DW) / vha_pkg::NDEG_PER_DEG);

    logic [3:0] v_reg;
    logic [4:0] rdy;

    logic [DW-1:0] num0_reg, num0_next;
    logic          zero0_reg;
    logic [DW-1:0] num1_reg;
    logic [QW-1:0] q1_reg, q1_next;
    logic          zero1_reg;
    logic [QW-1:0] q2_reg;
    logic          up2_reg, up2_next;
    logic          zero2_reg;
    logic [63:0]   prod;
    logic [DW-1:0] rem;
    logic [QW:0]   q_sum;

    logic [vha_pkg::HEADING_W-1:0] heading_reg, heading_next;
    logic                          zv_reg;

    assign rdy[4]      = dn_ready;
    assign rdy[3]      = !v_reg[3] || rdy[4];
    assign rdy[2]      = !v_reg[2] || rdy[3];
    assign rdy[1]      = !v_reg[1] || rdy[2];
    assign rdy[0]      = !v_reg[0] || rdy[1];
    assign up_ready    = rdy[0];
    assign dn_valid    = v_reg[3];
    assign heading     = heading_reg;
    assign zero_vector = zv_reg;

    // Scale and add half a degree unit for round-half-up
    always_comb
    begin
        num0_next = (DW'(angle) << FRACTION_BITS) + BIAS;
    end

    // Estimate the quotient from the top 32 bits
    always_comb
    begin
        prod    = 64'(num0_reg[DW-1:SH]) * 64'(RECIP);
        q1_next = QW'(prod >> 32);
    end

    // Remainder check: one more when a whole degree unit is left
    always_comb
    begin
        rem      = num1_reg - DW'(q1_reg) * DIVISOR;
        up2_next = (rem >= DIVISOR);
    end

    // Wrap 360 to 0, force 0 for the zero vector, keep the field width
    always_comb
    begin
        q_sum = {1'b0, q2_reg} + (QW+1)'(up2_reg);
        if (zero2_reg || q_sum >= (QW+1)'(FULL_Q))
            heading_next = '0;
        else
            heading_next = vha_pkg::HEADING_W'(q_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= up_valid;
            if (rdy[1])
                v_reg[1] <= v_reg[0];
            if (rdy[2])
                v_reg[2] <= v_reg[1];
            if (rdy[3])
                v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && up_valid)
        begin
            num0_reg  <= num0_next;
            zero0_reg <= zero;
        end
        if (rdy[1] && v_reg[0])
        begin
            num1_reg  <= num0_reg;
            q1_reg    <= q1_next;
            zero1_reg <= zero0_reg;
        end
        if (rdy[2] && v_reg[1])
        begin
            q2_reg    <= q1_reg;
            up2_reg   <= up2_next;
            zero2_reg <= zero1_reg;
        end
        if (rdy[3] && v_reg[2])
        begin
            heading_reg <= heading_next;
            zv_reg      <= zero2_reg;
        end
    end

endmodule

// File: rtl/vector_heading_angle.sv
// Top level of the vector heading angle block: direction of a 2D vector in degrees.
//
// Usage:
//   sample : valid/ready channel carrying one signed 16-bit (x, y) vector per item.
//   result : valid/ready channel carrying heading (degrees times 2^FRACTION_BITS,
//            0 up to but not including 360) and zero_vector, one item per sample.
//   cfg_wr_en / cfg_wr_data : write reference_mode (0 = from east, 1 = from north,
//            both counterclockwise). Write only while no item is in flight.
// Throughput: one item per cycle, sustained, as long as result.ready stays high.
// Pipeline: a sample passes through the input classify register, one CORDIC
//   rotation per stage, clamp / quadrant / wrap stages, then scale-and-round,
//   reciprocal multiply and remainder check stages, then the output register.
// Reset: every stage empties, result.valid drops, reference_mode returns to north.
// Stall: each stage holds its item while the stage after it is full and held, so a
//   stalled receiver fills the pipeline bubble by bubble; sample.ready falls only once
//   every stage holds an item. Nothing is dropped or repeated.
// The zero vector gives heading 0 with zero_vector set; exact axes bypass the
// CORDIC angle and land on exact quarter turns.
module vector_heading_angle #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    vha_in_if.sink     sample,
    vha_out_if.source  result,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data
);

    // Reference mode register, north after reset
    logic mode_reg;

    // CORDIC to angle stage
    logic                          cor_valid, cor_ready;
    logic signed [vha_pkg::ZW-1:0] cor_z;
    vha_pkg::tag_t                 cor_tag;

    // Angle stage to divider
    logic                          ang_valid, ang_ready;
    logic [vha_pkg::ANG_W-1:0]     ang_val;
    logic                          ang_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // Classify the vector and run the rotations; the mode rides in the tag
    vha_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (sample.valid),
        .up_ready    (sample.ready),
        .x_component (sample.x_component),
        .y_component (sample.y_component),
        .north       (mode_reg),
        .dn_valid    (cor_valid),
        .dn_ready    (cor_ready),
        .angle_z     (cor_z),
        .tag         (cor_tag)
    );

    // Turn the first-quadrant angle into a full-turn angle
    vha_angle u_angle (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cor_valid),
        .up_ready (cor_ready),
        .angle_z  (cor_z),
        .tag      (cor_tag),
        .dn_valid (ang_valid),
        .dn_ready (ang_ready),
        .angle    (ang_val),
        .zero     (ang_zero)
    );

    // Round to fixed-point degrees and register the result
    vha_divide #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divide (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (ang_valid),
        .up_ready    (ang_ready),
        .angle       (ang_val),
        .zero        (ang_zero),
        .dn_valid    (result.valid),
        .dn_ready    (result.ready),
        .heading     (result.heading),
        .zero_vector (result.zero_vector)
    );

endmodule

// File: rtl/vha_checker.sv
// Port-level checks of the vector heading angle block and their bind.
module vha_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [vha_pkg::HEADING_W-1:0] heading,
    input logic                          zero_vector
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(heading) && $stable(zero_vector))
        else $error("result item changed while stalled");

    a_zero_heading: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_vector |-> heading == '0)
        else $error("zero vector with nonzero heading");

    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
        else $error("input blocked while output drains");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("input blocked without output backpressure");

endmodule

bind vector_heading_angle vha_checker u_vha_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .heading      (result.heading),
    .zero_vector  (result.zero_vector)
);

// File: dv/testbench.sv
// Self-checking testbench for the vector heading angle block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Match the block's defaults; the predictor uses the same values.
    localparam int STAGES  = 16;
    localparam int FRAC    = 6;
    // Pipeline depth of the top level, used for the final settle.
    localparam int LATENCY =
        ((STAGES < vha_pkg::TABLE_LEN) ? STAGES : vha_pkg::TABLE_LEN) + 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 400;
    localparam int MODE_SPAN     = 100;

    localparam logic MODE_EAST  = 1'b0;
    localparam logic MODE_NORTH = 1'b1;

    localparam logic signed [vha_pkg::COMP_W-1:0] MOST_NEG = 16'sh8000;
    localparam logic signed [vha_pkg::COMP_W-1:0] MOST_POS = 16'sh7FFF;

    // Quarter turns in fixed-point degrees.
    localparam logic [vha_pkg::HEADING_W-1:0] QUARTER_0 = '0;
    localparam logic [vha_pkg::HEADING_W-1:0] QUARTER_1 = vha_pkg::HEADING_W'(90 << FRAC);
    localparam logic [vha_pkg::HEADING_W-1:0] QUARTER_2 = vha_pkg::HEADING_W'(180 << FRAC);
    localparam logic [vha_pkg::HEADING_W-1:0] QUARTER_3 = vha_pkg::HEADING_W'(270 << FRAC);

    typedef struct packed {
        logic [vha_pkg::HEADING_W-1:0] heading;
        logic                          zero_vector;
    } heading_t;

    // One directed probe; when known is set the result is typed in here,
    // otherwise it comes from the predictor.
    typedef struct {
        logic                               mode;
        logic signed [vha_pkg::COMP_W-1:0]  x;
        logic signed [vha_pkg::COMP_W-1:0]  y;
        bit                                 known;
        logic [vha_pkg::HEADING_W-1:0]      heading;
        logic                               zero_vector;
    } probe_row_t;

    typedef enum int {
        SHAPE_ZERO,
        SHAPE_AXIS,
        SHAPE_TINY,
        SHAPE_EDGE,
        SHAPE_DIAGONAL,
        SHAPE_NEAR_AXIS,
        SHAPE_ANY
    } vector_shape_t;

    localparam int PROBE_COUNT = 24;
    probe_row_t probe_rows [PROBE_COUNT] = '{
        // North reference (the reset value)
        '{MODE_NORTH, 16'sd0,    16'sd0,    1'b1, QUARTER_0, 1'b1},  // zero vector
        '{MODE_NORTH, 16'sd0,    16'sd1,    1'b1, QUARTER_0, 1'b0},  // exact +y
        '{MODE_NORTH, -16'sd1,   16'sd0,    1'b1, QUARTER_1, 1'b0},  // exact -x
        '{MODE_NORTH, 16'sd0,    -16'sd1,   1'b1, QUARTER_2, 1'b0},  // exact -y
        '{MODE_NORTH, 16'sd1,    16'sd0,    1'b1, QUARTER_3, 1'b0},  // exact +x
        '{MODE_NORTH, MOST_POS,  16'sd0,    1'b1, QUARTER_3, 1'b0},
        '{MODE_NORTH, MOST_NEG,  16'sd0,    1'b1, QUARTER_1, 1'b0},
        '{MODE_NORTH, 16'sd0,    MOST_POS,  1'b1, QUARTER_0, 1'b0},
        '{MODE_NORTH, 16'sd0,    MOST_NEG,  1'b1, QUARTER_2, 1'b0},
        '{MODE_NORTH, MOST_POS,  MOST_POS,  1'b0, '0, 1'b0},
        '{MODE_NORTH, MOST_NEG,  MOST_NEG,  1'b0, '0, 1'b0},
        '{MODE_NORTH, 16'sd1,    MOST_POS,  1'b0, '0, 1'b0},          // rounds up to a full turn
        '{MODE_NORTH, MOST_NEG,  MOST_POS,  1'b0, '0, 1'b0},
        '{MODE_NORTH, MOST_POS,  MOST_NEG,  1'b0, '0, 1'b0},
        // East reference
        '{MODE_EAST,  16'sd0,    16'sd0,    1'b1, QUARTER_0, 1'b1},
        '{MODE_EAST,  16'sd1,    16'sd0,    1'b1, QUARTER_0, 1'b0},
        '{MODE_EAST,  16'sd0,    16'sd1,    1'b1, QUARTER_1, 1'b0},
        '{MODE_EAST,  -16'sd1,   16'sd0,    1'b1, QUARTER_2, 1'b0},
        '{MODE_EAST,  16'sd0,    -16'sd1,   1'b1, QUARTER_3, 1'b0},
        '{MODE_EAST,  16'sd1,    16'sd1,    1'b0, '0, 1'b0},
        '{MODE_EAST,  MOST_POS,  -16'sd1,   1'b0, '0, 1'b0},          // rounds up to a full turn
        '{MODE_EAST,  -16'sd1,   MOST_NEG,  1'b0, '0, 1'b0},
        '{MODE_EAST,  MOST_NEG,  16'sd1,    1'b0, '0, 1'b0},
        '{MODE_EAST,  16'sd3,    -16'sd4,   1'b0, '0, 1'b0}
    };

    localparam logic signed [vha_pkg::COMP_W-1:0] EDGE_VALUES [6] = '{
        MOST_NEG, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, MOST_POS
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    vha_in_if  sample_ch ();
    vha_out_if result_ch ();

    vector_heading_angle #(
        .CORDIC_STAGES (STAGES),
        .FRACTION_BITS (FRAC)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Headings still owed by the block, oldest first.
    heading_t expected_headings [$];

    logic mode_now;            // shadow of reference_mode
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   mismatches;
    int   results_checked;
    int   north_items;
    int   east_items;
    int   zero_items;
    int   mode_writes;
    int   drain_pauses;

    // 4 ns clock, low half first so nothing sees an edge at time zero.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // First-quadrant angle of (ax, ay), both positive, in 1e-9 degree.
    // Rotate toward the x axis with floor shifts, accumulate the table
    // angles, then clamp into 0..90 degrees.
    function automatic longint cordic_angle(longint ax, longint ay);
        longint cx;
        longint cy;
        longint z;
        longint dx;
        longint dy;
        cx = ax * 65536;
        cy = ay * 65536;
        z  = 0;
        for (int i = 0; i < STAGES && i < vha_pkg::TABLE_LEN; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx += dx;
                cy -= dy;
                z  += longint'(vha_pkg::ATAN_NDEG[i]);
            end
            else
            begin
                cx -= dx;
                cy += dy;
                z  -= longint'(vha_pkg::ATAN_NDEG[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(vha_pkg::RIGHT_NDEG))
            z = longint'(vha_pkg::RIGHT_NDEG);
        return z;
    endfunction

    // Expected result of one vector under the given reference.
    function automatic heading_t predict_heading(logic signed [vha_pkg::COMP_W-1:0] x,
                                                 logic signed [vha_pkg::COMP_W-1:0] y,
                                                 logic mode);
        heading_t want;
        longint   right;
        longint   full;
        longint   ndeg;
        longint   sx;
        longint   sy;
        longint   t;
        longint   ang;
        longint   q;
        right = longint'(vha_pkg::RIGHT_NDEG);
        full  = longint'(vha_pkg::FULL_NDEG);
        ndeg  = longint'(vha_pkg::NDEG_PER_DEG);
        sx    = longint'(x);
        sy    = longint'(y);
        want  = '0;
        if (sx == 0 && sy == 0)
        begin
            want.zero_vector = 1'b1;
            return want;
        end
        // Exact axes skip the rotation and land on quarter turns.
        if (sx == 0)
            ang = (sy > 0) ? right : 3 * right;
        else if (sy == 0)
            ang = (sx > 0) ? 0 : 2 * right;
        else
        begin
            t = cordic_angle((sx < 0) ? -sx : sx, (sy < 0) ? -sy : sy);
            if (sx > 0 && sy > 0)
                ang = t;
            else if (sx < 0 && sy > 0)
                ang = 2 * right - t;
            else if (sx < 0)
                ang = 2 * right + t;
            else
                ang = full - t;
        end
        if (mode == MODE_NORTH)
            ang -= right;
        while (ang < 0)
            ang += full;
        while (ang >= full)
            ang -= full;
        // Round to nearest, ties up; a full turn folds back to zero.
        q = ((ang << FRAC) + ndeg / 2) / ndeg;
        if (q >= (longint'(360) << FRAC))
            q = 0;
        want.heading = vha_pkg::HEADING_W'(q);
        return want;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        heading_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_headings.size() == 0)
                note_mismatch($sformatf("unexpected result heading=%0d zero_vector=%0b",
                                        result_ch.heading, result_ch.zero_vector));
            else
            begin
                want = expected_headings.pop_front();
                results_checked++;
                if (result_ch.heading !== want.heading ||
                    result_ch.zero_vector !== want.zero_vector)
                    note_mismatch($sformatf(
                        "result %0d: heading exp %0d got %0d, zero_vector exp %0b got %0b",
                        results_checked, want.heading, result_ch.heading,
                        want.zero_vector, result_ch.zero_vector));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall at the rate of the current phase.
    // ------------------------------------------------------------------
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one vector, idle first at the phase's rate, hold until the
    // handshake, then log what the block owes for it.
    task automatic send_vector(logic signed [vha_pkg::COMP_W-1:0] x,
                               logic signed [vha_pkg::COMP_W-1:0] y,
                               heading_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.x_component <= x;
        sample_ch.y_component <= y;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        expected_headings.push_back(want);
        if (mode_now == MODE_NORTH)
            north_items++;
        else
            east_items++;
        if (want.zero_vector)
            zero_items++;
    endtask

    // Drop valid and hold until every owed result is back: the pipe is empty.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_headings.size() != 0);
    endtask

    // Change the reference only with nothing in flight.
    task automatic set_mode(logic mode);
        wait_for_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_now = mode;
        mode_writes++;
    endtask

    function automatic logic signed [vha_pkg::COMP_W-1:0] with_random_sign(int magnitude);
        logic signed [vha_pkg::COMP_W-1:0] v;
        v = vha_pkg::COMP_W'(magnitude);
        return $urandom_range(1) ? -v : v;
    endfunction

    // Pick a random vector; most are fully random, the rest aim at the
    // zero vector, the axes, tiny vectors, the extremes, the diagonals and the wrap.
    task automatic random_vector(output logic signed [vha_pkg::COMP_W-1:0] x,
                                 output logic signed [vha_pkg::COMP_W-1:0] y);
        int                                pick;
        vector_shape_t                     shape;
        logic signed [vha_pkg::COMP_W-1:0] t;
        pick  = $urandom_range(15);
        shape = (pick < SHAPE_ANY) ? vector_shape_t'(pick) : SHAPE_ANY;
        x = vha_pkg::COMP_W'($urandom);
        y = vha_pkg::COMP_W'($urandom);
        case (shape)
            SHAPE_ZERO:
            begin
                x = '0;
                y = '0;
            end
            SHAPE_AXIS:
            begin
                if (x == 0)
                    x = MOST_NEG;
                if ($urandom_range(1))
                    y = '0;
                else
                begin
                    y = x;
                    x = '0;
                end
            end
            SHAPE_TINY:
            begin
                x = with_random_sign($urandom_range(8));
                y = with_random_sign($urandom_range(8));
            end
            SHAPE_EDGE:
            begin
                x = EDGE_VALUES[$urandom_range(5)];
                y = EDGE_VALUES[$urandom_range(5)];
            end
            SHAPE_DIAGONAL:
            begin
                t = with_random_sign($urandom_range(32767));
                x = t;
                y = with_random_sign((t < 0) ? -t : t);
            end
            SHAPE_NEAR_AXIS:
            begin
                // Small off-axis part on a long component: lands just past
                // a quarter turn, or rounds into the full-turn wrap.
                x = with_random_sign($urandom_range(4, 1));
                y = with_random_sign($urandom_range(32767, 16384));
                if ($urandom_range(1))
                begin
                    t = x;
                    x = y;
                    y = t;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic signed [vha_pkg::COMP_W-1:0] vx;
        logic signed [vha_pkg::COMP_W-1:0] vy;
        heading_t                          want;

        sample_ch.valid       <= 1'b0;
        sample_ch.x_component <= '0;
        sample_ch.y_component <= '0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= 1'b0;
        rst_n                 <= 1'b0;
        mode_now          = MODE_NORTH;
        sender_idle_pct   = 30;
        receiver_idle_pct = 84;
        mismatches        = 0;
        results_checked   = 0;
        north_items       = 0;
        east_items        = 0;
        zero_items        = 0;
        mode_writes       = 0;
        drain_pauses      = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes: axes, extremes, zero vector and the wrap, in
        // both references. Switch the reference only when a row asks.
        foreach (probe_rows[i])
        begin
            if (probe_rows[i].mode != mode_now)
                set_mode(probe_rows[i].mode);
            if (probe_rows[i].known)
            begin
                want.heading     = probe_rows[i].heading;
                want.zero_vector = probe_rows[i].zero_vector;
            end
            else
                want = predict_heading(probe_rows[i].x, probe_rows[i].y, mode_now);
            send_vector(probe_rows[i].x, probe_rows[i].y, want);
        end

        // Random traffic in three idling phases: slow receiver, slow sender,
        // then full rate. Flip the reference every span so both settings
        // see each phase, and now and then hold off until the pipe drains.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 30;
                    receiver_idle_pct = 84;
                end
                1:
                begin
                    sender_idle_pct   = 84;
                    receiver_idle_pct = 30;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % MODE_SPAN == 0)
                    set_mode(((k / MODE_SPAN) + phase) % 2 == 0 ? MODE_EAST : MODE_NORTH);
                else if ($urandom_range(63) == 0)
                begin
                    wait_for_drain();
                    drain_pauses++;
                end
                random_vector(vx, vy);
                send_vector(vx, vy, predict_heading(vx, vy, mode_now));
            end
        end
        sample_ch.valid <= 1'b0;

        // Let the last results out, bounded, then let the pipeline settle.
        for (int n = 0; n < DRAIN_LIMIT && expected_headings.size() != 0; n++)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (expected_headings.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_headings.size()));

        $display("covered %0d vectors (%0d from north, %0d from east, %0d zero vectors)",
                 north_items + east_items, north_items, east_items, zero_items);
        $display("checked %0d results across %0d reference writes and %0d drain pauses, %0d mismatches",
                 results_checked, mode_writes, drain_pauses, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("timeout: %0d results still owed", expected_headings.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
